@@ rtl/sks_pkg.sv @@
// Shared types and constants for the sorted key set table.
package sks_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KEY_W        = 32;
    localparam int REQ_W        = 3;
    localparam int STATUS_W     = 3;
    localparam int POS_W        = 6;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT    = 3'd0,
        REQ_DELETE    = 3'd1,
        REQ_SEARCH    = 3'd2,
        REQ_DUMP_ASC  = 3'd3,
        REQ_DUMP_DESC = 3'd4
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHUP,
        S_SHDN,
        S_PUT,
        S_RESP,
        S_DUMP
    } t_state;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC,
        IDX_LAST
    } t_idx_op;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    typedef enum logic [1:0] {
        WR_UP,
        WR_DOWN,
        WR_KEY
    } t_wr_sel;

    typedef enum logic [1:0] {
        OK_ZERO,
        OK_KEY,
        OK_DATA
    } t_key_sel;

    typedef struct packed {
        t_idx_op  idx_op;
        t_cnt_op  cnt_op;
        logic     latch_key;
        logic     save_pos;
        logic     wr_en;
        t_wr_sel  wr_sel;
        logic     out_load;
        t_status  out_status;
        t_key_sel out_key_sel;
        logic     out_last;
        logic     out_pos_en;
        logic     dump_desc;
    } t_dp_cmd;

    typedef struct packed {
        logic idx_lt_cnt;
        logic key_lt;
        logic key_eq;
        logic idx_is_last;
        logic idx_is_pos;
        logic idx_is_zero;
        logic cnt_zero;
        logic cnt_full;
        logic out_free;
    } t_dp_stat;

endpackage

@@ rtl/sks_ctrl.sv @@
// Request sequencer for the sorted key set table.
module sks_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [sks_pkg::REQ_W-1:0]   i_req_type,
    input  sks_pkg::t_dp_stat           i_stat,
    output sks_pkg::t_dp_cmd            o_cmd
);
    import sks_pkg::*;

    t_state  r_state, n_state;
    t_req    r_req, n_req;
    t_status r_status, n_status;
    logic    w_found;
    logic    w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_req    <= REQ_INSERT;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_req    <= n_req;
            r_status <= n_status;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_status = r_status;
        o_ready  = 1'b0;
        w_found  = i_stat.idx_lt_cnt && i_stat.key_eq;
        w_last   = (r_req == REQ_DUMP_DESC) ? i_stat.idx_is_zero : i_stat.idx_is_last;

        o_cmd             = '0;
        o_cmd.idx_op      = IDX_HOLD;
        o_cmd.cnt_op      = CNT_HOLD;
        o_cmd.wr_sel      = WR_KEY;
        o_cmd.out_status  = r_status;
        o_cmd.out_key_sel = OK_ZERO;
        o_cmd.dump_desc   = (r_req == REQ_DUMP_DESC);

        case (r_state)
            S_IDLE: begin
                o_ready         = 1'b1;
                o_cmd.idx_op    = IDX_ZERO;
                o_cmd.latch_key = i_valid;
                if (i_valid) begin
                    case (i_req_type)
                        REQ_INSERT: begin
                            n_req   = REQ_INSERT;
                            n_state = S_SCAN;
                        end
                        REQ_DELETE, REQ_SEARCH: begin
                            n_req = t_req'(i_req_type);
                            if (i_stat.cnt_zero) begin
                                n_status = ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        REQ_DUMP_ASC, REQ_DUMP_DESC: begin
                            n_req = t_req'(i_req_type);
                            if (i_stat.cnt_zero) begin
                                n_status = ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                n_state = S_DUMP;
                                if (i_req_type == REQ_DUMP_DESC) begin
                                    o_cmd.idx_op = IDX_LAST;
                                end
                            end
                        end
                        default: begin
                            // undefined request: dropped without a result
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (i_stat.idx_lt_cnt && i_stat.key_lt) begin
                    o_cmd.idx_op = IDX_INC;
                end else begin
                    o_cmd.save_pos = 1'b1;
                    case (r_req)
                        REQ_INSERT: begin
                            if (w_found) begin
                                n_status = ST_DUP;
                                n_state  = S_RESP;
                            end else if (i_stat.cnt_full) begin
                                n_status = ST_FULL;
                                n_state  = S_RESP;
                            end else if (i_stat.idx_lt_cnt) begin
                                o_cmd.idx_op = IDX_LAST;
                                n_state      = S_SHUP;
                            end else begin
                                n_state = S_PUT;
                            end
                        end
                        REQ_DELETE: begin
                            if (!w_found) begin
                                n_status = ST_NOTFOUND;
                                n_state  = S_RESP;
                            end else if (i_stat.idx_is_last) begin
                                o_cmd.cnt_op = CNT_DEC;
                                n_status     = ST_OK;
                                n_state      = S_RESP;
                            end else begin
                                o_cmd.idx_op = IDX_INC;
                                n_state      = S_SHDN;
                            end
                        end
                        REQ_SEARCH: begin
                            n_status = w_found ? ST_OK : ST_NOTFOUND;
                            n_state  = S_RESP;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SHUP: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_UP;
                if (i_stat.idx_is_pos) begin
                    n_state = S_PUT;
                end else begin
                    o_cmd.idx_op = IDX_DEC;
                end
            end
            S_SHDN: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_DOWN;
                if (i_stat.idx_is_last) begin
                    o_cmd.cnt_op = CNT_DEC;
                    n_status     = ST_OK;
                    n_state      = S_RESP;
                end else begin
                    o_cmd.idx_op = IDX_INC;
                end
            end
            S_PUT: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_KEY;
                o_cmd.cnt_op = CNT_INC;
                n_status     = ST_OK;
                n_state      = S_RESP;
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load    = 1'b1;
                    o_cmd.out_last    = 1'b1;
                    o_cmd.out_key_sel = (r_req == REQ_SEARCH && r_status == ST_OK) ?
                                        OK_KEY : OK_ZERO;
                    n_state           = S_IDLE;
                end
            end
            S_DUMP: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load    = 1'b1;
                    o_cmd.out_status  = ST_OK;
                    o_cmd.out_key_sel = OK_DATA;
                    o_cmd.out_pos_en  = 1'b1;
                    o_cmd.out_last    = w_last;
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.idx_op = (r_req == REQ_DUMP_DESC) ? IDX_DEC : IDX_INC;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // a result is only pushed into a free output stage
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_stat.out_free)
        else $error("result loaded into a busy output stage");

    // a defined request always leaves idle
    a_req_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid && i_req_type <= REQ_DUMP_DESC)
        |=> (r_state != S_IDLE))
        else $error("accepted request did not start");

    // store is only written while moving entries or placing a key
    a_wr_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr_en |-> (r_state == S_SHUP || r_state == S_SHDN || r_state == S_PUT))
        else $error("store write outside an update");

endmodule

@@ rtl/sks_dpath.sv @@
// Key store, index and count registers, compare and output stage.
module sks_dpath #(
    parameter int CAPACITY = sks_pkg::CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic signed [sks_pkg::KEY_W-1:0]  i_key,
    input  sks_pkg::t_dp_cmd                  i_cmd,
    output sks_pkg::t_dp_stat                 o_stat,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [sks_pkg::STATUS_W-1:0]      o_status,
    output logic signed [sks_pkg::KEY_W-1:0]  o_key_out,
    output logic [sks_pkg::POS_W-1:0]         o_position,
    output logic                              o_last
);
    import sks_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [KEY_W-1:0]        r_mem [CAPACITY];
    logic signed [KEY_W-1:0] r_rdata;
    logic signed [KEY_W-1:0] r_key;
    logic [CW-1:0]           r_idx, n_idx;
    logic [CW-1:0]           r_pos;
    logic [CW-1:0]           r_count, n_count;
    logic [CW-1:0]           w_wr_idx;
    logic [KEY_W-1:0]        w_wr_data;
    logic [CW-1:0]           w_dump_pos;

    logic                    r_out_valid;
    logic [STATUS_W-1:0]     r_out_status;
    logic signed [KEY_W-1:0] r_out_key;
    logic [POS_W-1:0]        r_out_pos;
    logic                    r_out_last;

    always_comb begin
        case (i_cmd.idx_op)
            IDX_ZERO: n_idx = '0;
            IDX_INC:  n_idx = r_idx + CW'(1);
            IDX_DEC:  n_idx = r_idx - CW'(1);
            IDX_LAST: n_idx = r_count - CW'(1);
            default:  n_idx = r_idx;
        endcase
        case (i_cmd.cnt_op)
            CNT_INC: n_count = r_count + CW'(1);
            CNT_DEC: n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
        case (i_cmd.wr_sel)
            WR_UP: begin
                w_wr_idx  = r_idx + CW'(1);
                w_wr_data = r_rdata;
            end
            WR_DOWN: begin
                w_wr_idx  = r_idx - CW'(1);
                w_wr_data = r_rdata;
            end
            default: begin
                w_wr_idx  = r_pos;
                w_wr_data = r_key;
            end
        endcase
        w_dump_pos = i_cmd.dump_desc ? (r_count - CW'(1) - r_idx) : r_idx;
    end

    // read address follows the next index, so r_rdata tracks mem[r_idx]
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[w_wr_idx[AW-1:0]] <= w_wr_data;
        end
        r_rdata <= r_mem[n_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_idx   <= n_idx;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_key) begin
            r_key <= i_key;
        end
        if (i_cmd.save_pos) begin
            r_pos <= r_idx;
        end
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            r_out_last   <= i_cmd.out_last;
            r_out_pos    <= i_cmd.out_pos_en ? POS_W'(w_dump_pos) : '0;
            case (i_cmd.out_key_sel)
                OK_KEY:  r_out_key <= r_key;
                OK_DATA: r_out_key <= r_rdata;
                default: r_out_key <= '0;
            endcase
        end
    end

    always_comb begin
        o_stat.idx_lt_cnt  = (r_idx < r_count);
        o_stat.key_lt      = (r_rdata < r_key);
        o_stat.key_eq      = (r_rdata == r_key);
        o_stat.idx_is_last = (r_idx == r_count - CW'(1));
        o_stat.idx_is_pos  = (r_idx == r_pos);
        o_stat.idx_is_zero = (r_idx == '0);
        o_stat.cnt_zero    = (r_count == '0);
        o_stat.cnt_full    = (r_count == CW'(CAPACITY));
        o_stat.out_free    = !r_out_valid || i_ready;
    end

    assign o_valid    = r_out_valid;
    assign o_status   = r_out_status;
    assign o_key_out  = r_out_key;
    assign o_position = r_out_pos;
    assign o_last     = r_out_last;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_count)
        else $error("index beyond entry count");

    a_put_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_en && i_cmd.wr_sel == WR_KEY) |-> !o_stat.cnt_full)
        else $error("key placed into a full table");

endmodule

@@ rtl/sorted_key_set_table.sv @@
// Top level of the sorted key set table: sequencer plus key store datapath.
// A dump loads one beat per cycle into the result register while that register is free;
//   it stalls while a waiting beat is not taken on the result channel.
// Throughput: one request at a time; the next is taken once its final beat is loaded.
// Reset (i_rst_n low, synchronous) empties the table and the output stage; the store
//   contents are not cleared, only the entry count.
module sorted_key_set_table #(
    parameter int CAPACITY = sks_pkg::CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [sks_pkg::REQ_W-1:0]         i_req_type,
    input  logic signed [sks_pkg::KEY_W-1:0]  i_key,
    // result channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [sks_pkg::STATUS_W-1:0]      o_status,
    output logic signed [sks_pkg::KEY_W-1:0]  o_key_out,
    output logic [sks_pkg::POS_W-1:0]         o_position,
    output logic                              o_last
);
    import sks_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencer: takes a request beat only when idle, walks the store,
    // and pushes each result beat into the datapath output register.
    sks_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (i_req_type),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Datapath: sorted key store with registered read, index/count
    // registers, signed compare, and the result register that decouples
    // the result channel so a new request can enter while a beat waits.
    sks_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_key      (i_key),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_status   (o_status),
        .o_key_out  (o_key_out),
        .o_position (o_position),
        .o_last     (o_last)
    );

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the sorted key set table.
`timescale 1ns / 100ps

module tb;
    import sks_pkg::*;

    localparam int CAPACITY        = CAPACITY_DEF;
    localparam int REQ_FIRST_SPARE = int'(REQ_DUMP_DESC) + 1;   // codes the block ignores
    localparam int REQ_LAST_CODE   = (1 << REQ_W) - 1;
    localparam int POOL_DEPTH      = 24;                         // more keys than slots
    localparam int DRAIN_CYCLES    = 4 * CAPACITY + 16;          // covers a full shift walk
    localparam int CYCLE_LIMIT     = 400000;
    localparam int REPORT_MAX      = 10;
    localparam int RANDOM_ITEMS    = 320;

    // one result beat
    typedef struct packed {
        t_status                  status;
        logic signed [KEY_W-1:0]  key_out;
        logic [POS_W-1:0]         position;
        logic                     last;
    } t_table_beat;

    // Mirror of the table contents plus the queue of beats still owed by the block.
    class key_table_scoreboard;
        int          held_keys[$];      // ascending, distinct
        t_table_beat owed_beats[$];
        int          mismatches;

        function new();
            mismatches = 0;
        endfunction

        function int pending();
            return owed_beats.size();
        endfunction

        function void queue_beat(t_status st, int key, int pos, bit is_last);
            t_table_beat b;
            b.status   = st;
            b.key_out  = key;
            b.position = pos[POS_W-1:0];
            b.last     = is_last;
            owed_beats.push_back(b);
        endfunction

        // slot of the first held key not below the given one
        function int slot_for(int key);
            int idx;
            idx = 0;
            while (idx < held_keys.size() && held_keys[idx] < key) idx++;
            return idx;
        endfunction

        // accepted request beat: update the mirror and queue the beats it causes
        function void note_request(logic [REQ_W-1:0] req, int key);
            int n;
            int idx;
            bit hit;
            n   = held_keys.size();
            idx = slot_for(key);
            hit = (idx < n) && (held_keys[idx] == key);
            if (req > REQ_DUMP_DESC) return;     // ignored, no beat
            if (req == REQ_INSERT) begin
                // duplicate is reported ahead of full
                if (hit) begin
                    queue_beat(ST_DUP, 0, 0, 1'b1);
                end else if (n >= CAPACITY) begin
                    queue_beat(ST_FULL, 0, 0, 1'b1);
                end else begin
                    held_keys.insert(idx, key);
                    queue_beat(ST_OK, 0, 0, 1'b1);
                end
            end else if (n == 0) begin
                queue_beat(ST_EMPTY, 0, 0, 1'b1);
            end else if (req == REQ_DELETE || req == REQ_SEARCH) begin
                if (!hit) begin
                    queue_beat(ST_NOTFOUND, 0, 0, 1'b1);
                end else if (req == REQ_SEARCH) begin
                    queue_beat(ST_OK, key, 0, 1'b1);
                end else begin
                    held_keys.delete(idx);
                    queue_beat(ST_OK, 0, 0, 1'b1);
                end
            end else begin
                // dumps: position counts emission order in both directions
                for (int i = 0; i < n; i++) begin
                    queue_beat(ST_OK, held_keys[(req == REQ_DUMP_ASC) ? i : n - 1 - i],
                               i, i == n - 1);
                end
            end
        endfunction

        // accepted result beat: compare with the oldest owed beat
        function void check_beat(logic [STATUS_W-1:0] st, logic signed [KEY_W-1:0] key,
                                 logic [POS_W-1:0] pos, logic is_last);
            t_table_beat want;
            if (owed_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: unexpected beat status %0d key %0d pos %0d last %0d",
                             $realtime, st, key, pos, is_last);
                return;
            end
            want = owed_beats.pop_front();
            if (want.status !== st || want.key_out !== key ||
                want.position !== pos || want.last !== is_last) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: beat mismatch exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                             $realtime, want.status, want.key_out, want.position,
                             want.last, st, key, pos, is_last);
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_ready;
    logic [REQ_W-1:0]         i_req_type;
    logic signed [KEY_W-1:0]  i_key;
    logic                     o_valid;
    logic                     i_ready;
    logic [STATUS_W-1:0]      o_status;
    logic signed [KEY_W-1:0]  o_key_out;
    logic [POS_W-1:0]         o_position;
    logic                     o_last;

    key_table_scoreboard sb;
    int                  tx_idle_pct;
    int                  rx_idle_pct;
    int                  cycle_count;
    int                  key_pool[POOL_DEPTH];
    bit                  filling;

    sorted_key_set_table #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (i_req_type),
        .i_key      (i_key),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_status   (o_status),
        .o_key_out  (o_key_out),
        .o_position (o_position),
        .o_last     (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: values seen right after the edge are the ones the edge used.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_beat(o_status, o_key_out, o_position, o_last);
        i_ready <= i_rst_n && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sorted_key_set_table verification failed");
            $finish;
        end
    end

    // Drive one request beat. Valid is only dropped when a gap is taken, so it is
    // never lowered and raised in the same step between back-to-back beats.
    task automatic send_request(input logic [REQ_W-1:0] req, input int key);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        i_valid    <= 1'b1;
        i_req_type <= req;
        i_key      <= key;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(req, key);
    endtask

    // Key for a lookup or removal: mostly one that is held, so the walk goes deep.
    function automatic int pick_lookup_key();
        int n;
        n = sb.held_keys.size();
        if (n > 0 && $urandom_range(0, 99) < 70)
            return sb.held_keys[$urandom_range(0, n - 1)];
        if ($urandom_range(0, 99) < 80)
            return key_pool[$urandom_range(0, POOL_DEPTH - 1)];
        return $urandom;
    endfunction

    // Random traffic that swings the table between empty and full.
    task automatic run_random_phase(input int items);
        int               sent;
        int               roll;
        int               key;
        logic [REQ_W-1:0] req;
        sent = 0;
        while (sent < items) begin
            if (sb.held_keys.size() >= CAPACITY) filling = 1'b0;
            if (sb.held_keys.size() == 0)        filling = 1'b1;
            if ($urandom_range(0, 29) == 0)
                key_pool[$urandom_range(4, POOL_DEPTH - 1)] = $urandom;
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                req = REQ_W'($urandom_range(REQ_FIRST_SPARE, REQ_LAST_CODE));
            end else if (roll < (filling ? 64 : 19)) begin
                req = REQ_INSERT;
            end else if (roll < (filling ? 76 : 74)) begin
                req = REQ_DELETE;
            end else if (roll < 89) begin
                req = REQ_SEARCH;
            end else if (roll < 95) begin
                req = REQ_DUMP_ASC;
            end else begin
                req = REQ_DUMP_DESC;
            end
            if (req == REQ_INSERT)
                key = ($urandom_range(0, 99) < 80) ? key_pool[$urandom_range(0, POOL_DEPTH - 1)]
                                                   : $urandom;
            else if (req == REQ_DELETE || req == REQ_SEARCH)
                key = pick_lookup_key();
            else
                key = $urandom;
            send_request(req, key);
            if (req <= REQ_DUMP_DESC) sent++;
        end
    endtask

    initial begin
        sb          = new();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        filling     = 1'b1;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_req_type <= REQ_INSERT;
        i_key      <= '0;
        key_pool[0] = 32'h8000_0000;    // most negative
        key_pool[1] = 32'h7fff_ffff;    // most positive
        key_pool[2] = 0;
        key_pool[3] = -1;
        for (int i = 4; i < POOL_DEPTH; i++) key_pool[i] = $urandom;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 33;
        rx_idle_pct = 64;

        // directed: empty table, extremes, duplicate, hits and misses, both dumps
        send_request(REQ_DELETE,    0);
        send_request(REQ_SEARCH,    5);
        send_request(REQ_DUMP_ASC,  0);
        send_request(REQ_DUMP_DESC, 0);
        send_request(REQ_INSERT,    0);
        send_request(REQ_INSERT,    32'h8000_0000);
        send_request(REQ_INSERT,    32'h7fff_ffff);
        send_request(REQ_INSERT,    -1);
        send_request(REQ_INSERT,    0);
        send_request(REQ_SEARCH,    32'h8000_0000);
        send_request(REQ_SEARCH,    1);
        send_request(REQ_DELETE,    12345);
        send_request(REQ_DUMP_ASC,  0);
        send_request(REQ_DUMP_DESC, 0);
        for (int c = REQ_FIRST_SPARE; c <= REQ_LAST_CODE; c++)
            send_request(REQ_W'(c), $urandom);
        send_request(REQ_DELETE,    32'h7fff_ffff);
        send_request(REQ_DELETE,    32'h8000_0000);
        send_request(REQ_SEARCH,    -1);
        send_request(REQ_DUMP_DESC, 32'hffff_ffff);

        run_random_phase(RANDOM_ITEMS / 3);
        tx_idle_pct = 64;
        rx_idle_pct = 33;
        run_random_phase(RANDOM_ITEMS / 3);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random_phase(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

        i_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        // stray beats after the last owed one still count as failures
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("sorted_key_set_table verification clean");
        else
            $display("sorted_key_set_table verification failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/sks_pkg.sv
rtl/sks_ctrl.sv
rtl/sks_dpath.sv
rtl/sorted_key_set_table.sv
tb/tb.sv
